// ===== rtl/assert_macros.svh =====
// Assertion helpers, included by bitmap_id_allocator.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/bia_pkg.sv =====
package bia_pkg;

   // Default number of identifiers.
   localparam int DEF_ID_COUNT = 1024;

   // Bitmap word geometry.
   localparam int WORD_BITS = 32;
   localparam int BIT_AW    = 5;

   // Payload widths.
   localparam int ID_W     = 10;
   localparam int STATUS_W = 2;

   // Request actions.
   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RELEASED  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic load;
      logic look;
      logic commit;
      logic report_full;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic any_free;
      logic is_alloc;
   } sts_type;

   // Position of the lowest set bit of a word; zero when the word is empty.
   function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_AW-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = BIT_AW'(i);
         end
      end
      return pos;
   endfunction

   // Bits of bitmap word w that stand for identifiers below id_count.
   function automatic logic [WORD_BITS-1:0] word_valid_mask(input logic [31:0] w,
                                                            input logic [31:0] id_count);
      logic [31:0] base;
      logic [31:0] left;
      base = w << BIT_AW;
      left = id_count - base;
      if (base >= id_count) begin
         return '0;
      end
      if (left >= 32'(WORD_BITS)) begin
         return '1;
      end
      return (WORD_BITS'(1) << left[BIT_AW-1:0]) - WORD_BITS'(1);
   endfunction

endpackage

// ===== rtl/bia_ctrl.sv =====
module bia_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bia_pkg::sts_type sts,
   output bia_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_MODIFY
   } state_type;

   state_type state_ff;
   state_type state_in;

   // The block takes words in the idle state and in the write-back cycle.
   assign busy = (state_ff == S_CLEAR) || (state_ff == S_LOOK);

   // Next state and commands to the datapath.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            if (sts.is_alloc && !sts.any_free) begin
               cmd.report_full = 1'b1;
               state_in        = S_IDLE;
            end else begin
               state_in = S_MODIFY;
            end
         end
         S_MODIFY: begin
            cmd.commit = 1'b1;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_LOOK;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass over the bitmap.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/bia_datapath.sv =====
module bia_datapath #(
   parameter int ID_COUNT = bia_pkg::DEF_ID_COUNT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bia_pkg::cmd_type             cmd,
   output bia_pkg::sts_type             sts,
   input  logic                         req_action,
   input  logic [bia_pkg::ID_W-1:0]     req_release_id,
   output logic                         rsp_valid,
   output logic [bia_pkg::ID_W-1:0]     rsp_granted_id,
   output logic [bia_pkg::STATUS_W-1:0] rsp_status
);

   localparam int WB        = bia_pkg::WORD_BITS;
   localparam int MAP_WORDS = (ID_COUNT + WB - 1) / WB;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int GROUPS    = (MAP_WORDS + WB - 1) / WB;
   localparam int GROUP_AW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int SUM_BITS  = GROUPS * WB;
   localparam int SUM_AW    = GROUP_AW + bia_pkg::BIT_AW;

   // Bitmap memory, one word per 32 identifiers.
   logic [WB-1:0]               mem [MAP_WORDS];
   logic [WB-1:0]               rd_ff;

   // Summary bit per word (word has a free bit) and flag per group of words.
   logic [SUM_BITS-1:0]         sum_ff;
   logic [SUM_BITS-1:0]         sum_in;
   logic [GROUPS-1:0]           grp_ff;
   logic [GROUPS-1:0]           grp_in;

   // Latched request and the word under work.
   logic                        act_ff;
   logic [bia_pkg::ID_W-1:0]    rid_ff;
   logic [WORD_AW-1:0]          addr_ff;
   logic [WORD_AW-1:0]          clr_ff;

   logic                        rsp_valid_ff;
   logic [bia_pkg::ID_W-1:0]    rsp_id_ff;
   logic [bia_pkg::STATUS_W-1:0] rsp_status_ff;

   logic [GROUP_AW-1:0]         grp_idx;
   logic [WB-1:0]               grp_bits;
   logic [bia_pkg::BIT_AW-1:0]  word_sel;
   logic [SUM_AW-1:0]           found_idx;
   logic [WORD_AW-1:0]          rel_word;
   logic [WORD_AW-1:0]          rd_addr;
   logic                        rel_ok;
   logic [bia_pkg::BIT_AW-1:0]  bit_pos;
   logic [WB-1:0]               new_word;
   logic                        wr_en;
   logic [WORD_AW-1:0]          wr_addr;
   logic [WB-1:0]               wr_data;
   logic [31:0]                 gid_wide;
   logic                        is_alloc;

   assign is_alloc = (act_ff == bia_pkg::ACT_ALLOC);

   // Two-level search: lowest group with a free word, then lowest word in it.
   always_comb begin
      grp_idx = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_ff[g]) begin
            grp_idx = GROUP_AW'(g);
         end
      end
   end

   assign grp_bits  = sum_ff[grp_idx * WB +: WB];
   assign word_sel  = bia_pkg::lowest_set(grp_bits);
   assign found_idx = {grp_idx, word_sel};
   assign rel_word  = WORD_AW'(rid_ff[bia_pkg::ID_W-1:bia_pkg::BIT_AW]);
   assign rd_addr   = is_alloc ? found_idx[WORD_AW-1:0] : rel_word;
   assign rel_ok    = (32'(rid_ff) < 32'(ID_COUNT));

   // Word modification for the write-back cycle.
   assign bit_pos  = bia_pkg::lowest_set(rd_ff);
   assign new_word = is_alloc ? (rd_ff & ~(WB'(1) << bit_pos))
                              : (rd_ff | (WB'(1) << rid_ff[bia_pkg::BIT_AW-1:0]));
   assign gid_wide = (32'(addr_ff) << bia_pkg::BIT_AW) | 32'(bit_pos);

   // Memory write port: clearing pass or write-back.
   always_comb begin
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = bia_pkg::word_valid_mask(32'(clr_ff), 32'(ID_COUNT));
      end else begin
         wr_en   = cmd.commit && (is_alloc || rel_ok);
         wr_addr = addr_ff;
         wr_data = new_word;
      end
   end

   // Summary update after a write-back, then the group flags from it.
   always_comb begin
      sum_in = sum_ff;
      if (cmd.commit && (is_alloc || rel_ok)) begin
         sum_in[addr_ff] = |new_word;
      end
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = |sum_in[g * WB +: WB];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.look) begin
         rd_ff   <= mem[rd_addr];
         addr_ff <= rd_addr;
      end
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         rid_ff <= req_release_id;
      end
   end

   // Summaries, clearing counter and response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SUM_BITS; i++) begin
            sum_ff[i] <= (i < MAP_WORDS);
         end
         grp_ff       <= '1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         grp_ff       <= grp_in;
         rsp_valid_ff <= cmd.commit || cmd.report_full;
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + WORD_AW'(1);
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (cmd.report_full) begin
         rsp_id_ff     <= '0;
         rsp_status_ff <= bia_pkg::ST_FULL;
      end else if (cmd.commit) begin
         if (is_alloc) begin
            rsp_id_ff     <= gid_wide[bia_pkg::ID_W-1:0];
            rsp_status_ff <= bia_pkg::ST_ALLOCATED;
         end else begin
            rsp_id_ff     <= '0;
            rsp_status_ff <= bia_pkg::ST_RELEASED;
         end
      end
   end

   assign sts.clear_last = (clr_ff == WORD_AW'(MAP_WORDS - 1));
   assign sts.any_free   = |grp_ff;
   assign sts.is_alloc   = is_alloc;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_id_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== rtl/bitmap_id_allocator.sv =====
// Channel    Ports                                   Handshake
// request    req_action, req_release_id              start high while busy low
// response   rsp_granted_id, rsp_status              rsp_valid high for one cycle
//
// Each word passes through a lookup cycle that reads one bitmap word and a
// write-back cycle on the single memory write port; the next word is taken in
// the write-back cycle. An allocate that finds no free identifier answers from
// the lookup cycle alone, with no write-back. After reset the block stays busy
// while it fills the bitmap. Responses cannot be stalled by the receiver.
`include "assert_macros.svh"

module bitmap_id_allocator #(
   parameter int ID_COUNT = bia_pkg::DEF_ID_COUNT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_action,
   input  logic [bia_pkg::ID_W-1:0]     req_release_id,
   output logic                         rsp_valid,
   output logic [bia_pkg::ID_W-1:0]     rsp_granted_id,
   output logic [bia_pkg::STATUS_W-1:0] rsp_status
);

   bia_pkg::cmd_type cmd;
   bia_pkg::sts_type sts;
   logic             rsp_no_grant;

   // Sequencing of the clearing pass, lookup and write-back.
   bia_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Bitmap memory, summaries and response registers.
   bia_datapath #(
      .ID_COUNT (ID_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_action     (req_action),
      .req_release_id (req_release_id),
      .rsp_valid      (rsp_valid),
      .rsp_granted_id (rsp_granted_id),
      .rsp_status     (rsp_status)
   );

   // A response word that hands out no identifier.
   assign rsp_no_grant = rsp_valid && (rsp_status != bia_pkg::ST_ALLOCATED);

   // An accepted word is always followed by a lookup cycle.
   `ASSERT_CLK(a_accept_then_busy, start && !busy |=> busy, "accepted word not followed by lookup")

   // Reset always starts the clearing pass.
   `ASSERT_CLK_ALWAYS(a_reset_clears, reset |=> busy, "block not busy after reset")

   // Only a successful allocate carries a nonzero identifier.
   `ASSERT_CLK(a_zero_id, rsp_no_grant |-> rsp_granted_id == '0, "nonzero id without a grant")

endmodule
